// ----- rtl/hce_pkg.sv -----
package hce_pkg;

    localparam int MAX_NODES = 16;
    localparam int VW        = 5;
    localparam int ROW_W     = $clog2(MAX_NODES);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_NEXT  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic cfg_wr;
        logic add_edge;
        logic clear;
        logic step;
        logic put_vertex;
        logic put_none;
    } hce_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic hit;
        logic empty;
        logic final_vtx;
        logic out_free;
    } hce_stat_t;

endpackage

// ----- rtl/hamiltonian_cycle_enumerator.sv -----
// edit, clear and node count writes produce no result item
// a next request runs the search one backtracking step at a time (one advance of the
// top path entry via a priority pick over the adjacency row), so its search
// latency is data dependent and can grow exponentially with the vertex count
// a found cycle then streams n_act+1 items (n_act is node_count clamped to 2..16), one per cycle without stall
// reset (async, active low) clears the graph, sets node count 16, restarts search
module hamiltonian_cycle_enumerator
    import hce_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    // item input
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    opcode,
    input  logic [VW-1:0] node_a,
    input  logic [VW-1:0] node_b,
    // node count write
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [VW-1:0] node_count,
    // result output
    output logic          out_valid,
    input  logic          out_stall,
    output logic          found,
    output logic [VW-1:0] vertex,
    output logic          last
);

    hce_cmd_t  cmd;
    hce_stat_t stat;

    // sequencer: idle, search steps, cycle emission, not-found emission
    hce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .cfg_valid (cfg_valid),
        .stat      (stat),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // adjacency matrix, path stack, visited set and result register
    hce_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_data  (node_count),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .found     (found),
        .vertex    (vertex),
        .last      (last)
    );

endmodule

// ----- rtl/hce_ctrl.sv -----
module hce_ctrl
    import hce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] opcode,
    input  logic       cfg_valid,
    input  hce_stat_t  stat,
    output logic       in_stall,
    output logic       cfg_ready,
    output hce_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_NONE   = 4'b1000
    } hce_state_t;

    hce_state_t state_reg;
    hce_state_t state_next;

    always_comb
    begin
        cmd        = '0;
        in_stall   = 1'b1;
        cfg_ready  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cfg_ready  = 1'b1;
                cmd.cfg_wr = cfg_valid;
                if (in_valid)
                begin
                    unique case (opcode)
                        OP_ADD:   cmd.add_edge = 1'b1;
                        OP_CLEAR: cmd.clear    = 1'b1;
                        OP_NEXT:  state_next   = stat.done ? ST_NONE : ST_SEARCH;
                        default:  ;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (stat.hit)
                begin
                    state_next = ST_EMIT;
                end
                else if (stat.empty)
                begin
                    state_next = ST_NONE;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.put_vertex = 1'b1;
                    if (stat.final_vtx)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NONE:
            begin
                if (stat.out_free)
                begin
                    cmd.put_none = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/hce_dpath.sv -----
module hce_dpath
    import hce_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  hce_cmd_t      cmd,
    input  logic [VW-1:0] cfg_data,
    input  logic [VW-1:0] node_a,
    input  logic [VW-1:0] node_b,
    input  logic          out_stall,
    output hce_stat_t     stat,
    output logic          out_valid,
    output logic          found,
    output logic [VW-1:0] vertex,
    output logic          last
);

    logic [MAX_NODES-1:0] adj_reg [MAX_NODES];
    logic [MAX_NODES-1:0] adj_next [MAX_NODES];
    logic [VW-1:0]        count_reg, count_next;
    logic [VW-1:0]        level_reg, level_next;
    logic [VW-1:0]        cur_reg, cur_next;
    logic [VW-1:0]        prev_reg, prev_next;
    logic [MAX_NODES-1:0] used_reg, used_next;
    logic                 done_reg, done_next;
    logic [VW-1:0]        idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg;
    logic [VW-1:0]        vertex_reg;
    logic                 last_reg;
    logic [VW-1:0]        stack_reg [MAX_NODES+1];

    logic [VW-1:0]        n_act;
    logic [MAX_NODES-1:0] row_prev;
    logic [MAX_NODES-1:0] close_mask;
    logic [MAX_NODES-1:0] cand_mask;
    logic [VW-1:0]        cand;
    logic                 has_cand;
    logic                 edge_ok;
    logic                 restart;
    logic [VW-1:0]        rd_addr;
    logic [VW-1:0]        rd_val;
    logic                 final_vtx;
    logic                 out_free;

    function automatic logic [MAX_NODES-1:0] vbit(input logic [VW-1:0] v);
        logic [MAX_NODES-1:0] one;
        one = {{(MAX_NODES-1){1'b0}}, 1'b1};
        return one << (v - VW'(1));
    endfunction

    // active vertex count, clamped
    always_comb
    begin
        if (count_reg < VW'(2))
        begin
            n_act = VW'(2);
        end
        else if (count_reg > VW'(MAX_NODES))
        begin
            n_act = VW'(MAX_NODES);
        end
        else
        begin
            n_act = count_reg;
        end
    end

    // next admissible vertex after cur at this level
    always_comb
    begin
        row_prev   = adj_reg[ROW_W'(prev_reg - VW'(1))];
        // closing edge back to vertex 1, row 0 by symmetry
        close_mask = (level_reg == n_act) ? adj_reg[0] : '1;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            cand_mask[i] = row_prev[i] & ~used_reg[i] & close_mask[i]
                         & (VW'(i + 1) > cur_reg) & (VW'(i + 1) <= n_act);
        end
        cand = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (cand_mask[i])
            begin
                cand = VW'(i + 1);
            end
        end
        has_cand = |cand_mask;
    end

    assign final_vtx = (idx_reg == n_act + VW'(1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign rd_addr   = cmd.put_vertex ? (final_vtx ? VW'(1) : idx_reg)
                                      : level_reg - VW'(2);
    assign rd_val    = (rd_addr == VW'(1)) ? VW'(1) : stack_reg[rd_addr];

    assign edge_ok = (node_a != '0) && (node_a <= VW'(MAX_NODES))
                  && (node_b != '0) && (node_b <= VW'(MAX_NODES));
    assign restart = cmd.cfg_wr || cmd.clear || (cmd.add_edge && edge_ok);

    always_comb
    begin
        adj_next       = adj_reg;
        count_next     = count_reg;
        level_next     = level_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        used_next      = used_reg;
        done_next      = done_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.clear)
        begin
            for (int r = 0; r < MAX_NODES; r++)
            begin
                adj_next[r] = '0;
            end
        end
        if (cmd.add_edge && edge_ok)
        begin
            adj_next[ROW_W'(node_a - VW'(1))][ROW_W'(node_b - VW'(1))] = 1'b1;
            adj_next[ROW_W'(node_b - VW'(1))][ROW_W'(node_a - VW'(1))] = 1'b1;
        end
        if (cmd.cfg_wr)
        begin
            count_next = cfg_data;
        end

        if (restart)
        begin
            level_next = VW'(2);
            cur_next   = '0;
            prev_next  = VW'(1);
            used_next  = {{(MAX_NODES-1){1'b0}}, 1'b1};
            done_next  = 1'b0;
        end
        else if (cmd.step)
        begin
            if (has_cand)
            begin
                if (level_reg == n_act)
                begin
                    cur_next = cand;
                    idx_next = VW'(1);
                end
                else
                begin
                    level_next = level_reg + VW'(1);
                    cur_next   = '0;
                    prev_next  = cand;
                    used_next  = used_reg | vbit(cand);
                end
            end
            else if (level_reg == VW'(2))
            begin
                done_next = 1'b1;
                cur_next  = '0;
            end
            else
            begin
                // backtrack one level
                level_next = level_reg - VW'(1);
                cur_next   = prev_reg;
                prev_next  = rd_val;
                used_next  = used_reg & ~vbit(prev_reg);
            end
        end

        if (cmd.put_vertex)
        begin
            idx_next       = idx_reg + VW'(1);
            out_valid_next = 1'b1;
        end
        else if (cmd.put_none)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_NODES; r++)
            begin
                adj_reg[r] <= '0;
            end
            count_reg     <= VW'(16);
            level_reg     <= VW'(2);
            cur_reg       <= '0;
            prev_reg      <= VW'(1);
            used_reg      <= {{(MAX_NODES-1){1'b0}}, 1'b1};
            done_reg      <= 1'b0;
            idx_reg       <= VW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            adj_reg       <= adj_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            used_reg      <= used_next;
            done_reg      <= done_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // path stack and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.step && has_cand && !restart)
        begin
            stack_reg[level_reg] <= cand;
        end
        if (cmd.put_vertex)
        begin
            found_reg  <= 1'b1;
            vertex_reg <= rd_val;
            last_reg   <= final_vtx;
        end
        else if (cmd.put_none)
        begin
            found_reg  <= 1'b0;
            vertex_reg <= '0;
            last_reg   <= 1'b1;
        end
    end

    assign stat.done      = done_reg;
    assign stat.hit       = has_cand && (level_reg == n_act);
    assign stat.empty     = !has_cand && (level_reg == VW'(2));
    assign stat.final_vtx = final_vtx;
    assign stat.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign vertex    = vertex_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_used_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(level_reg) - 1)
        else $error("visited set does not match search level");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg >= VW'(2)) && (level_reg <= n_act))
        else $error("search level out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put_vertex || cmd.put_none) |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");
`endif

endmodule
